// ===== design/spn_pkg.sv =====
// Shared types, constants and table functions for the 16-bit SPN cipher.
// No dependencies; used by every module of the block.
package spn_pkg;

    // Number of cipher rounds (2 to 4) and the resulting pipeline depth
    localparam int SPN_ROUNDS = 4;
    localparam int SPN_DEPTH  = SPN_ROUNDS + 1;

    // Register reset values: default S-box and the transpose permutation
    localparam logic [63:0] SBOX_RESET = 64'h7095_C6A3_8BF2_1D4E;
    localparam logic [63:0] PERM_RESET = 64'hFB73_EA62_D951_C840;

    // Configuration port geometry: three registers on a 64-bit bus at 8-byte spacing
    localparam int APB_AW = 5;
    localparam int APB_DW = 64;
    localparam int KEY_W  = 32;

    typedef enum logic [1:0] {
        MODE_ENC     = 2'd0,
        MODE_DEC     = 2'd1,
        MODE_CBC_ENC = 2'd2,
        MODE_CBC_DEC = 2'd3
    } spn_mode_t;

    typedef enum logic [1:0] {
        REG_KEY  = 2'd0,
        REG_SBOX = 2'd1,
        REG_PERM = 2'd2
    } spn_reg_t;

    typedef struct packed {
        spn_mode_t   mode;
        logic [15:0] data_in;
        logic [15:0] chain_in;
    } spn_in_t;

    typedef struct packed {
        logic [15:0] data_out;
        logic        table_error;
    } spn_out_t;

    // One item as it travels down the round pipeline
    typedef struct packed {
        spn_mode_t   mode;
        logic [15:0] x;
        logic [15:0] chain;
    } spn_stage_t;

    // Forward and inverse tables handed to every inner round stage
    typedef struct packed {
        logic [63:0] sbox;
        logic [63:0] perm;
        logic [63:0] inv_sbox;
        logic [63:0] inv_perm;
    } spn_tables_t;

    function automatic logic [3:0] nib(input logic [63:0] t, input logic [3:0] i);
        return t[{i, 2'b00} +: 4];
    endfunction

    function automatic logic is_bijection(input logic [63:0] t);
        logic [15:0] seen;
        seen = '0;
        for (int i = 0; i < 16; i++) begin
            seen[nib(t, 4'(i))] = 1'b1;
        end
        return &seen;
    endfunction

    function automatic logic [63:0] invert_table(input logic [63:0] t);
        logic [63:0] inv;
        inv = '0;
        for (int i = 0; i < 16; i++) begin
            inv = inv | (64'(i) << {nib(t, 4'(i)), 2'b00});
        end
        return inv;
    endfunction

    function automatic logic [15:0] substitute(input logic [15:0] x, input logic [63:0] t);
        logic [15:0] y;
        for (int k = 0; k < 4; k++) begin
            y[4*k +: 4] = nib(t, x[4*k +: 4]);
        end
        return y;
    endfunction

    function automatic logic [15:0] permute(input logic [15:0] x, input logic [63:0] t);
        logic [15:0] y;
        y = '0;
        for (int i = 0; i < 16; i++) begin
            y = y | (16'(x[i]) << nib(t, 4'(i)));
        end
        return y;
    endfunction

    // Round key r: key shifted right by four times (rounds minus r)
    function automatic logic [15:0] round_key(input logic [KEY_W-1:0] key, input int r);
        return 16'(key >> (4 * (SPN_ROUNDS - r)));
    endfunction

    function automatic logic is_decrypt(input spn_mode_t m);
        return (m == MODE_DEC) || (m == MODE_CBC_DEC);
    endfunction

endpackage

// ===== design/spn_round.sv =====
// One inner round stage of the SPN pipeline, with its own stage register.
// Depends on spn_pkg for the stage and table types and table functions.
module spn_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 prev_valid,
    input  spn_pkg::spn_stage_t  prev,
    input  spn_pkg::spn_tables_t tables,
    input  logic [15:0]          enc_key,
    input  logic [15:0]          dec_key,
    output logic                 valid,
    output spn_pkg::spn_stage_t  stage
);

    logic                valid_reg;
    spn_pkg::spn_stage_t stage_reg;
    spn_pkg::spn_stage_t stage_next;
    logic [15:0]         sub_val;

    // Encrypt: substitute, permute, add key; decrypt: inverse substitute, add key, inverse permute
    always_comb
    begin
        stage_next = prev;
        if (spn_pkg::is_decrypt(prev.mode))
        begin
            sub_val      = spn_pkg::substitute(prev.x, tables.inv_sbox);
            stage_next.x = spn_pkg::permute(sub_val ^ dec_key, tables.inv_perm);
        end
        else
        begin
            sub_val      = spn_pkg::substitute(prev.x, tables.sbox);
            stage_next.x = spn_pkg::permute(sub_val, tables.perm) ^ enc_key;
        end
    end

    // Advance the valid bit with the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    // Hold the item unless the stage advances
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

// ===== design/spn_block_cipher_16bit.sv =====
// 16-bit four-round SPN cipher, ECB or CBC, encrypt or decrypt.
// Throughput: one item per cycle while the result channel is not stalled;
// one register stage per round plus an input stage.
// An output stall holds every stage back to the first bubble in the same cycle.
// Reset (rst_n low, asynchronous) empties the pipeline and restores key and tables.
// Depends on spn_pkg and spn_round.
module spn_block_cipher_16bit (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          item_valid,
    output logic                          item_ready,
    input  spn_pkg::spn_in_t              item,
    // result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output spn_pkg::spn_out_t             result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spn_pkg::APB_AW-1:0]    paddr,
    input  logic [spn_pkg::APB_DW-1:0]    pwdata,
    output logic [spn_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int R = spn_pkg::SPN_ROUNDS;

    // Configuration registers and tables derived from them
    logic [spn_pkg::KEY_W-1:0] key_reg;
    logic [63:0]               sbox_reg;
    logic [63:0]               perm_reg;
    logic [63:0]               inv_sbox_reg;
    logic [63:0]               inv_perm_reg;
    logic                      table_error_reg;
    spn_pkg::spn_tables_t      tables;
    spn_pkg::spn_reg_t         reg_sel;
    logic                      cfg_write;

    // Pipeline
    logic [R:0]                adv;
    logic                      stage_valid [R];
    spn_pkg::spn_stage_t       stage_q     [R];
    logic                      stage0_valid_reg;
    spn_pkg::spn_stage_t       stage0_reg;
    spn_pkg::spn_stage_t       stage0_next;
    logic                      result_valid_reg;
    spn_pkg::spn_out_t         result_reg;
    spn_pkg::spn_out_t         result_next;
    logic [15:0]               last_sub;
    logic [15:0]               last_val;

    // Configuration decode
    assign pready    = 1'b1;
    assign reg_sel   = spn_pkg::spn_reg_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            spn_pkg::REG_KEY:  prdata = 64'(key_reg);
            spn_pkg::REG_SBOX: prdata = sbox_reg;
            spn_pkg::REG_PERM: prdata = perm_reg;
            default:           prdata = '0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            sbox_reg <= spn_pkg::SBOX_RESET;
            perm_reg <= spn_pkg::PERM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                spn_pkg::REG_KEY:  key_reg  <= pwdata[spn_pkg::KEY_W-1:0];
                spn_pkg::REG_SBOX: sbox_reg <= pwdata;
                spn_pkg::REG_PERM: perm_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    // Derive inverse tables and the bijection check, registered from the current tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_sbox_reg    <= spn_pkg::invert_table(spn_pkg::SBOX_RESET);
            inv_perm_reg    <= spn_pkg::invert_table(spn_pkg::PERM_RESET);
            table_error_reg <= 1'b0;
        end
        else
        begin
            inv_sbox_reg    <= spn_pkg::invert_table(sbox_reg);
            inv_perm_reg    <= spn_pkg::invert_table(perm_reg);
            table_error_reg <= !spn_pkg::is_bijection(sbox_reg)
                               || !spn_pkg::is_bijection(perm_reg);
        end
    end

    assign tables.sbox     = sbox_reg;
    assign tables.perm     = perm_reg;
    assign tables.inv_sbox = inv_sbox_reg;
    assign tables.inv_perm = inv_perm_reg;

    // Stage advance: a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[R] = !result_valid_reg || result_ready;
        for (int i = R - 1; i >= 0; i--)
        begin
            adv[i] = !stage_valid[i] || adv[i+1];
        end
    end

    assign item_ready = adv[0];

    // Input stage: CBC chaining on encrypt, then whitening key
    always_comb
    begin
        stage0_next.mode  = item.mode;
        stage0_next.chain = item.chain_in;
        if (spn_pkg::is_decrypt(item.mode))
        begin
            stage0_next.x = item.data_in ^ spn_pkg::round_key(key_reg, R);
        end
        else if (item.mode == spn_pkg::MODE_CBC_ENC)
        begin
            stage0_next.x = item.data_in ^ item.chain_in ^ spn_pkg::round_key(key_reg, 0);
        end
        else
        begin
            stage0_next.x = item.data_in ^ spn_pkg::round_key(key_reg, 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage0_valid_reg <= 1'b0;
        end
        else if (adv[0])
        begin
            stage0_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            stage0_reg <= stage0_next;
        end
    end

    assign stage_valid[0] = stage0_valid_reg;
    assign stage_q[0]     = stage0_reg;

    // Inner rounds
    for (genvar s = 1; s < R; s++)
    begin : g_round
        spn_round u_round (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv[s]),
            .prev_valid (stage_valid[s-1]),
            .prev       (stage_q[s-1]),
            .tables     (tables),
            .enc_key    (spn_pkg::round_key(key_reg, s)),
            .dec_key    (spn_pkg::round_key(key_reg, R - s)),
            .valid      (stage_valid[s]),
            .stage      (stage_q[s])
        );
    end

    // Last round: substitute, final key, CBC chaining on decrypt, error override
    always_comb
    begin
        if (spn_pkg::is_decrypt(stage_q[R-1].mode))
        begin
            last_sub = spn_pkg::substitute(stage_q[R-1].x, inv_sbox_reg);
            last_val = last_sub ^ spn_pkg::round_key(key_reg, 0);
            if (stage_q[R-1].mode == spn_pkg::MODE_CBC_DEC)
            begin
                last_val = last_val ^ stage_q[R-1].chain;
            end
        end
        else
        begin
            last_sub = spn_pkg::substitute(stage_q[R-1].x, sbox_reg);
            last_val = last_sub ^ spn_pkg::round_key(key_reg, R);
        end
        result_next.table_error = table_error_reg;
        result_next.data_out    = table_error_reg ? 16'h0000 : last_val;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv[R])
        begin
            result_valid_reg <= stage_valid[R-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[R])
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/spn_checker.sv =====
// Port-level checks for the SPN cipher, bound to the top level.
// Depends on spn_pkg for the payload types and the pipeline depth.
module spn_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_ready,
    input logic                    result_valid,
    input logic                    result_ready,
    input spn_pkg::spn_out_t       result
);

    localparam int CW = $clog2(spn_pkg::SPN_DEPTH + 1);

    logic [CW-1:0] outstanding_reg;
    logic [CW-1:0] outstanding_next;

    // Count items accepted but not yet delivered
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (item_valid && item_ready)
        begin
            outstanding_next = outstanding_next + CW'(1);
        end
        if (result_valid && result_ready)
        begin
            outstanding_next = outstanding_next - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A table error always clears the data
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.table_error |-> result.data_out == 16'h0000)
        else $error("data not cleared on table error");

    // With the output empty the pipeline cannot be full
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty output");

    // No more items in flight than the pipeline holds
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CW'(spn_pkg::SPN_DEPTH))
        else $error("too many items in flight");

    // No result without an item behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outstanding_reg != '0)
        else $error("result without an accepted item");

endmodule

bind spn_block_cipher_16bit spn_checker u_spn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
